// ===== design/assert_macros.svh =====
// Assertion helpers shared by the decoder RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define B64PD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define B64PD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/b64pd_pkg.sv =====
// Shared types, codes and character maps for the base64/percent decoder.
// No dependencies; used by b64pd_step and the top level.
`default_nettype none

package b64pd_pkg;

  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_COMPLETE  = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [1:0] count;
    logic [1:0] status;
  } result_t;

  // {ok, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (c == 8'h2B || c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F || c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'd0;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/base64_percent_stream_decoder_core.sv =====
// Base64 stream decoder with percent unescape, top level: input register,
// b64pd_step update logic, result register. Depends on b64pd_pkg,
// b64pd_step and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, in_char, is_last) takes one raw
//   character per transfer; is_last marks the end of a stream.
//   Output channel (out_valid/out_stall) gives exactly one result per input
//   character: up to three bytes, byte_count, and status (running, complete,
//   invalid encoding, underflow). Unused bytes are zero.
//   A character taken into the input register passes through b64pd_step
//   into the result register once the output can take it. Throughput: one
//   character per cycle while the receiver does not stall.
//   Reset (rst, synchronous) empties both registers and clears the decoder
//   state. The last character of a stream clears the state again.
//   When the receiver stalls, the result is held; the input register still
//   takes one more character if it is empty, after which in_stall is raised
//   until the result is taken.
`default_nettype none

`include "assert_macros.svh"

module base64_percent_stream_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte_0,
  output logic [7:0]      out_byte_1,
  output logic [7:0]      out_byte_2,
  output logic [1:0]      byte_count,
  output logic [1:0]      status
);

  logic                s1_valid;
  b64pd_pkg::item_t    s1_item;
  b64pd_pkg::result_t  step_result;
  b64pd_pkg::result_t  res;
  logic                out_ready;
  logic                fire;

  assign out_ready = !out_valid || !out_stall;
  assign fire      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.ch   <= in_char;
      s1_item.last <= is_last;
    end
  end

  b64pd_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_result;
    end
  end

  assign out_byte_0 = res.byte_0;
  assign out_byte_1 = res.byte_1;
  assign out_byte_2 = res.byte_2;
  assign byte_count = res.count;
  assign status     = res.status;

  `B64PD_ASSERT_IMPL(a_bytes_ok_status, clk, rst, (out_valid && byte_count != 2'd0), (status == b64pd_pkg::ST_RUNNING || status == b64pd_pkg::ST_COMPLETE), "bytes delivered with error status")
  `B64PD_ASSERT_IMPL(a_unused_byte_zero, clk, rst, (out_valid && byte_count != 2'd3), (out_byte_2 == 8'd0), "unused byte not zero")
  `B64PD_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(res)), "stalled result changed")

endmodule

`default_nettype wire

// ===== design/b64pd_step.sv =====
// Decoder state and per-character update: percent unescape, group fill,
// padding and sticky error handling. Depends on b64pd_pkg, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module b64pd_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire b64pd_pkg::item_t  item,
  output b64pd_pkg::result_t     result
);

  logic [5:0] store [3];
  logic [1:0] fill;
  logic [1:0] esc;
  logic [3:0] hex_high;
  logic       pad;
  logic       group_bad;
  logic [1:0] failed;

  logic [5:0] store_next [3];
  logic [1:0] fill_next;
  logic [1:0] esc_next;
  logic [3:0] hex_high_next;
  logic       pad_next;
  logic       group_bad_next;
  logic [1:0] failed_next;

  logic [4:0]  hx;
  logic [6:0]  sx;
  logic [7:0]  ch_eff;
  logic        add;
  logic        bad_v;
  logic [1:0]  st;
  logic [1:0]  n;
  logic [23:0] word;

  assign hx = b64pd_pkg::hex_of(item.ch);
  assign sx = b64pd_pkg::sextet_of(ch_eff);
  assign word = {store[0], store[1], store[2], sx[5:0]};

  always_comb begin
    store_next     = store;
    fill_next      = fill;
    esc_next       = esc;
    hex_high_next  = hex_high;
    pad_next       = pad;
    group_bad_next = group_bad;
    failed_next    = failed;
    ch_eff         = item.ch;
    add            = 1'b0;
    bad_v          = 1'b0;
    n              = 2'd0;
    st             = b64pd_pkg::ST_RUNNING;
    result         = '0;

    if (failed != b64pd_pkg::ST_RUNNING) begin
      st = failed;
    end else begin
      unique case (esc)
        b64pd_pkg::ESC_NONE: begin
          if (item.ch == b64pd_pkg::CH_PCT) begin
            if (item.last) st = b64pd_pkg::ST_UNDERFLOW;
            else esc_next = b64pd_pkg::ESC_PCT;
          end else begin
            add = 1'b1;
          end
        end
        b64pd_pkg::ESC_PCT: begin
          if (item.last) begin
            st = b64pd_pkg::ST_UNDERFLOW;
          end else if (!hx[4]) begin
            st = b64pd_pkg::ST_INVALID;
          end else begin
            hex_high_next = hx[3:0];
            esc_next      = b64pd_pkg::ESC_HEX;
          end
        end
        default: begin
          esc_next = b64pd_pkg::ESC_NONE;
          if (!hx[4]) begin
            st = b64pd_pkg::ST_INVALID;
          end else begin
            add    = 1'b1;
            ch_eff = {hex_high, hx[3:0]};
          end
        end
      endcase
    end

    if (add) begin
      case (fill)
        2'd0, 2'd1: begin
          if (!sx[6]) group_bad_next = 1'b1;
          store_next[fill] = sx[5:0];
          fill_next = fill + 2'd1;
        end
        2'd2: begin
          if (ch_eff == b64pd_pkg::CH_EQ) pad_next = 1'b1;
          else if (!sx[6]) group_bad_next = 1'b1;
          store_next[2] = sx[5:0];
          fill_next = 2'd3;
        end
        default: begin
          bad_v = group_bad;
          if (pad) begin
            if (ch_eff != b64pd_pkg::CH_EQ) bad_v = 1'b1;
            n = 2'd1;
          end else if (ch_eff == b64pd_pkg::CH_EQ) begin
            n = 2'd2;
          end else begin
            if (!sx[6]) bad_v = 1'b1;
            n = 2'd3;
          end
          fill_next      = 2'd0;
          pad_next       = 1'b0;
          group_bad_next = 1'b0;
          if (bad_v) begin
            st = b64pd_pkg::ST_INVALID;
          end else begin
            result.byte_0 = word[23:16];
            result.byte_1 = (n != 2'd1) ? word[15:8] : 8'd0;
            result.byte_2 = (n == 2'd3) ? word[7:0] : 8'd0;
            result.count  = n;
          end
        end
      endcase
    end

    if (st != b64pd_pkg::ST_RUNNING) begin
      result.byte_0 = 8'd0;
      result.byte_1 = 8'd0;
      result.byte_2 = 8'd0;
      result.count  = 2'd0;
      failed_next   = st;
    end else if (item.last) begin
      if (fill_next != 2'd0) begin
        st = b64pd_pkg::ST_INVALID;
        result.byte_0 = 8'd0;
        result.byte_1 = 8'd0;
        result.byte_2 = 8'd0;
        result.count  = 2'd0;
      end else begin
        st = b64pd_pkg::ST_COMPLETE;
      end
    end
    result.status = st;

    if (item.last) begin
      store_next[0]  = 6'd0;
      store_next[1]  = 6'd0;
      store_next[2]  = 6'd0;
      fill_next      = 2'd0;
      esc_next       = b64pd_pkg::ESC_NONE;
      hex_high_next  = 4'd0;
      pad_next       = 1'b0;
      group_bad_next = 1'b0;
      failed_next    = b64pd_pkg::ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store[0]  <= 6'd0;
      store[1]  <= 6'd0;
      store[2]  <= 6'd0;
      fill      <= 2'd0;
      esc       <= b64pd_pkg::ESC_NONE;
      hex_high  <= 4'd0;
      pad       <= 1'b0;
      group_bad <= 1'b0;
      failed    <= b64pd_pkg::ST_RUNNING;
    end else if (fire) begin
      store     <= store_next;
      fill      <= fill_next;
      esc       <= esc_next;
      hex_high  <= hex_high_next;
      pad       <= pad_next;
      group_bad <= group_bad_next;
      failed    <= failed_next;
    end
  end

  `B64PD_ASSERT(a_last_clears, clk, rst, (fire && item.last) |=> (fill == 2'd0 && esc == b64pd_pkg::ESC_NONE && failed == b64pd_pkg::ST_RUNNING), "state not cleared after last transfer")
  `B64PD_ASSERT(a_failed_sticky, clk, rst, (fire && !item.last && failed != b64pd_pkg::ST_RUNNING) |=> (failed == $past(failed)), "sticky error changed")
  `B64PD_ASSERT(a_hold_idle, clk, rst, !fire |=> ($stable(fill) && $stable(failed) && $stable(esc)), "state moved without a transfer")

endmodule

`default_nettype wire
